>>> sv/wsws_pkg.sv
// wsws_pkg: shared types and constants for the word sequence window search
// holds the transfer payload structs, function codes and controller/datapath links
// no dependencies
package wsws_pkg;

    localparam int WORD_W    = 32;
    localparam int INDEX_W   = 11;
    localparam int OUT_IDX_W = 10;

    localparam logic [1:0] FUNC_LOAD_HAY = 2'd0;
    localparam logic [1:0] FUNC_LOAD_NDL = 2'd1;
    localparam logic [1:0] FUNC_SEARCH   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [WORD_W-1:0]  hash_word;
        logic               restart;
        logic [INDEX_W-1:0] start_index;
        logic [INDEX_W-1:0] end_index;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] match_index;
    } t_out_item;

    typedef struct packed {
        logic load_hay;
        logic load_ndl;
        logic latch;
        logic check;
        logic fetch;
        logic next_k;
        logic next_pos;
        logic set_hit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic check_ok;
        logic word_eq;
        logic last_k;
        logic last_pos;
    } t_sts;

endpackage

>>> sv/wsws_dp.sv
// wsws_dp: datapath with haystack and needle stores, counts, position counters
// and the result register; depends on wsws_pkg
module wsws_dp #(
    parameter int HAYSTACK_DEPTH = 1024,
    parameter int NEEDLE_DEPTH   = 256,
    parameter int HASH_WIDTH     = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsws_pkg::t_in_item i_in_data,
    input  wsws_pkg::t_cmd     i_cmd,
    output wsws_pkg::t_sts     o_sts,
    output wsws_pkg::t_out_item o_out_data
);
    import wsws_pkg::*;

    localparam int HAW  = $clog2(HAYSTACK_DEPTH);
    localparam int NAW  = (NEEDLE_DEPTH > 1) ? $clog2(NEEDLE_DEPTH) : 1;
    localparam int HCW  = $clog2(HAYSTACK_DEPTH + 1);
    localparam int NCW  = $clog2(NEEDLE_DEPTH + 1);
    localparam int PW0  = (HCW > NCW) ? HCW : NCW;
    localparam int PW   = (PW0 > INDEX_W) ? PW0 : INDEX_W;

    logic [HASH_WIDTH-1:0] hay_mem [HAYSTACK_DEPTH];
    logic [HASH_WIDTH-1:0] ndl_mem [NEEDLE_DEPTH];

    logic [HCW-1:0]        r_hay_cnt;
    logic [NCW-1:0]        r_ndl_cnt;
    logic [PW-1:0]         r_pos;
    logic [PW-1:0]         r_end;
    logic [NCW-1:0]        r_k;
    logic                  r_hit;
    logic [HASH_WIDTH-1:0] r_hay_rd;
    logic [HASH_WIDTH-1:0] r_ndl_rd;
    t_out_item             r_out;

    logic [HASH_WIDTH-1:0] w_word;
    logic [HCW-1:0]        n_hay_base;
    logic [NCW-1:0]        n_ndl_base;
    logic                  w_hay_room;
    logic                  w_ndl_room;
    logic [PW-1:0]         w_hs;
    logic [PW-1:0]         w_ns;
    logic [PW-1:0]         w_maxpos;
    logic [PW-1:0]         w_end_eff;
    logic [PW-1:0]         w_hay_addr;
    logic [NCW-1:0]        w_k_inc;

    assign w_word     = HASH_WIDTH'(i_in_data.hash_word);
    assign n_hay_base = i_in_data.restart ? '0 : r_hay_cnt;
    assign n_ndl_base = i_in_data.restart ? '0 : r_ndl_cnt;
    assign w_hay_room = n_hay_base < HCW'(HAYSTACK_DEPTH);
    assign w_ndl_room = n_ndl_base < NCW'(NEEDLE_DEPTH);

    // bounds check; the search start sits in r_pos at this point
    assign w_hs      = PW'(r_hay_cnt);
    assign w_ns      = PW'(r_ndl_cnt);
    assign w_maxpos  = w_hs - w_ns;
    assign w_end_eff = (r_end == '0 || r_end > w_maxpos) ? w_maxpos : r_end;

    assign w_hay_addr = r_pos + PW'(r_k);
    assign w_k_inc    = r_k + NCW'(1);

    always_comb begin
        o_sts.check_ok = (w_ns != '0) && (w_hs != '0) && !(w_ns > w_hs)
                         && !(r_pos > w_hs) && !(w_end_eff < r_pos);
        o_sts.word_eq  = r_hay_rd == r_ndl_rd;
        o_sts.last_k   = w_k_inc == r_ndl_cnt;
        o_sts.last_pos = r_pos == r_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hay_cnt <= '0;
            r_ndl_cnt <= '0;
        end else begin
            if (i_cmd.load_hay) begin
                r_hay_cnt <= w_hay_room ? n_hay_base + HCW'(1) : n_hay_base;
            end
            if (i_cmd.load_ndl) begin
                r_ndl_cnt <= w_ndl_room ? n_ndl_base + NCW'(1) : n_ndl_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hay && w_hay_room) begin
            hay_mem[n_hay_base[HAW-1:0]] <= w_word;
        end
        if (i_cmd.load_ndl && w_ndl_room) begin
            ndl_mem[n_ndl_base[NAW-1:0]] <= w_word;
        end
        if (i_cmd.fetch) begin
            r_hay_rd <= hay_mem[w_hay_addr[HAW-1:0]];
            r_ndl_rd <= ndl_mem[r_k[NAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pos <= PW'(i_in_data.start_index);
            r_end <= PW'(i_in_data.end_index);
        end
        if (i_cmd.check) begin
            r_end <= w_end_eff;
            r_k   <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.next_k) begin
            r_k <= w_k_inc;
        end
        if (i_cmd.next_pos) begin
            r_pos <= r_pos + PW'(1);
            r_k   <= '0;
        end
        if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.found       <= r_hit;
            r_out.match_index <= r_hit ? r_pos[OUT_IDX_W-1:0] : '0;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> sv/wsws_ctrl.sv
// wsws_ctrl: controller state machine for loads and the search walk
// drives datapath commands from status; depends on wsws_pkg
module wsws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_func,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  wsws_pkg::t_sts i_sts,
    output wsws_pkg::t_cmd o_cmd
);
    import wsws_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_FETCH = 5'b00100,
        S_CMP   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        FUNC_LOAD_HAY: o_cmd.load_hay = 1'b1;
                        FUNC_LOAD_NDL: o_cmd.load_ndl = 1'b1;
                        FUNC_SEARCH: begin
                            o_cmd.latch = 1'b1;
                            n_state     = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.check_ok ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (i_sts.word_eq) begin
                    if (i_sts.last_k) begin
                        o_cmd.set_hit = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.next_k = 1'b1;
                        n_state      = S_FETCH;
                    end
                end else if (i_sts.last_pos) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_pos = 1'b1;
                    n_state        = S_FETCH;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/word_sequence_window_search.sv
// word_sequence_window_search: top level, finds the first window of the haystack
// that equals the needle; instantiates wsws_ctrl and wsws_dp, uses wsws_pkg
// loads are taken one per cycle while no search is in progress
// a search runs a bounds check, then for each word compare a store read then a check
// the single read port of each store sets the walk rate; result sits in an output register
// synchronous active-low reset clears counts, state and output valid; stores are not cleared
module word_sequence_window_search #(
    parameter int HAYSTACK_DEPTH = 1024,
    parameter int NEEDLE_DEPTH   = 256,
    parameter int HASH_WIDTH     = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wsws_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wsws_pkg::t_out_item o_out_data
);
    import wsws_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    wsws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_in_data.func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    wsws_dp #(
        .HAYSTACK_DEPTH (HAYSTACK_DEPTH),
        .NEEDLE_DEPTH   (NEEDLE_DEPTH),
        .HASH_WIDTH     (HASH_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

>>> sv/wsws_chk.sv
// wsws_chk: port-level checker for word_sequence_window_search, bound to the top
// depends on wsws_pkg
module wsws_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input wsws_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input wsws_pkg::t_out_item o_out_data
);
    import wsws_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.match_index == '0)
        else $error("match index nonzero on not found");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.func == FUNC_SEARCH |=> o_in_stall)
        else $error("input not held off after search transfer");

endmodule

bind word_sequence_window_search wsws_chk u_wsws_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
